[hdl/i2cw_pkg.sv]
// Package for the write-only I2C pin sequencer.
// Holds the command codes, the queue entry type and the sequencing constants.
// No dependencies.
`default_nettype none
package i2cw_pkg;

  // Bus command codes
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e_t;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned BIT_CNT_W   = $clog2(BYTE_BITS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  // Each bit slot, start and stop is three pin levels
  localparam logic [1:0] PHASE_LAST = 2'd2;

  // One queued request
  typedef struct packed {
    cmd_e_t               cmd;
    logic [BYTE_BITS-1:0] data;
  } q_entry_t;

  // Queue head as seen by the sequencer
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage
`default_nettype wire

[hdl/i2cw_front.sv]
// Front end: takes input requests and classifies them.
// The unused command code is swallowed; the rest are pushed to the queue.
// Depends on i2cw_pkg.
`default_nettype none
module i2cw_front (
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     cmd,
  input  wire logic [i2cw_pkg::BYTE_BITS-1:0] data_byte,
  input  wire logic                           q_full,
  output logic                                push,
  output i2cw_pkg::q_entry_t                  entry
);

  i2cw_pkg::cmd_e_t code;

  // Classify the command; the unused code is accepted and dropped
  always_comb begin
    case (cmd)
      i2cw_pkg::CMD_START: code = i2cw_pkg::CMD_START;
      i2cw_pkg::CMD_WRITE: code = i2cw_pkg::CMD_WRITE;
      i2cw_pkg::CMD_STOP:  code = i2cw_pkg::CMD_STOP;
      default:             code = i2cw_pkg::CMD_NONE;
    endcase
  end

  assign in_ready   = !q_full;
  assign push       = in_valid && !q_full && (code != i2cw_pkg::CMD_NONE);
  assign entry.cmd  = code;
  assign entry.data = data_byte;

endmodule
`default_nettype wire

[hdl/i2cw_queue.sv]
// Short request queue between the front end and the sequencer.
// Register based, DEPTH entries, one push and one pop per cycle; a push is taken only while not full.
// Depends on i2cw_pkg.
`default_nettype none
module i2cw_queue #(
  parameter int unsigned DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire i2cw_pkg::q_entry_t push_entry,
  output logic                    full,
  input  wire logic               pop,
  output i2cw_pkg::q_head_t       head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  i2cw_pkg::q_entry_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full       = (count == CNT_FULL);
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/i2cw_seq.sv]
// Back end: steps through the pin levels of one request per level a cycle while the output is not stalled.
// Keeps the current line levels and drives the registered output.
// Depends on i2cw_pkg.
`default_nettype none
module i2cw_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire i2cw_pkg::q_head_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   scl,
  output logic                   sda,
  output logic                   hold,
  output logic                   last
);

  logic                               busy;
  i2cw_pkg::cmd_e_t                   kind;
  logic [1:0]                         phase;
  logic [i2cw_pkg::BIT_CNT_W-1:0]     bit_cnt;
  logic [i2cw_pkg::BYTE_BITS-1:0]     shift;
  logic                               line_scl;
  logic                               line_sda;
  logic                               adv;
  logic                               lvl_scl;
  logic                               lvl_sda;
  logic                               lvl_hold;
  logic                               lvl_last;
  logic                               ack_slot;

  assign ack_slot = (bit_cnt == i2cw_pkg::BIT_CNT_W'(i2cw_pkg::BYTE_BITS));
  assign adv      = busy && (!out_valid || out_ready);
  assign pop      = head.valid && (!busy || (adv && lvl_last));
  assign scl      = line_scl;
  assign sda      = line_sda;

  // Next pin level from command, phase and bit slot
  always_comb begin
    lvl_scl  = line_scl;
    lvl_sda  = line_sda;
    lvl_hold = 1'b0;
    lvl_last = (phase == i2cw_pkg::PHASE_LAST);
    case (kind)
      i2cw_pkg::CMD_START: begin
        case (phase)
          2'd0:    begin lvl_scl = 1'b1; lvl_sda = 1'b1; lvl_hold = 1'b1; end
          2'd1:    begin lvl_scl = 1'b1; lvl_sda = 1'b0; lvl_hold = 1'b1; end
          default: begin lvl_scl = 1'b0; lvl_sda = 1'b0; lvl_hold = 1'b0; end
        endcase
      end
      i2cw_pkg::CMD_STOP: begin
        case (phase)
          2'd0:    begin lvl_scl = 1'b0; lvl_sda = 1'b0; lvl_hold = 1'b1; end
          2'd1:    begin lvl_scl = 1'b1; lvl_sda = 1'b0; lvl_hold = 1'b1; end
          default: begin lvl_scl = 1'b1; lvl_sda = 1'b1; lvl_hold = 1'b1; end
        endcase
      end
      i2cw_pkg::CMD_WRITE: begin
        lvl_last = ack_slot && (phase == i2cw_pkg::PHASE_LAST);
        case (phase)
          // data set with clock unchanged; ack slot releases SDA, no hold
          2'd0: begin
            lvl_scl  = line_scl;
            lvl_sda  = ack_slot ? 1'b1 : shift[i2cw_pkg::BYTE_BITS-1];
            lvl_hold = !ack_slot;
          end
          2'd1:    begin lvl_scl = 1'b1; lvl_sda = line_sda; lvl_hold = 1'b1; end
          default: begin lvl_scl = 1'b0; lvl_sda = line_sda; lvl_hold = 1'b0; end
        endcase
      end
      default: begin
        lvl_last = 1'b1;
      end
    endcase
  end

  // Sequencer state, line levels and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      line_scl  <= 1'b1;
      line_sda  <= 1'b1;
      kind      <= i2cw_pkg::CMD_NONE;
      phase     <= '0;
      bit_cnt   <= '0;
    end else begin
      if (adv) begin
        line_scl  <= lvl_scl;
        line_sda  <= lvl_sda;
        hold      <= lvl_hold;
        last      <= lvl_last;
        out_valid <= 1'b1;
        if (phase == i2cw_pkg::PHASE_LAST) begin
          phase <= '0;
          if (kind == i2cw_pkg::CMD_WRITE) begin
            bit_cnt <= bit_cnt + 1'b1;
            shift   <= {shift[i2cw_pkg::BYTE_BITS-2:0], 1'b0};
          end
        end else begin
          phase <= phase + 1'b1;
        end
        if (lvl_last) begin
          busy <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // load the next request, possibly straight after the last level
      if (pop) begin
        busy    <= 1'b1;
        kind    <= head.entry.cmd;
        phase   <= '0;
        bit_cnt <= '0;
        shift   <= head.entry.data;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/i2c_write_master_pins.sv]
// A request enters the queue at acceptance, passes the sequencer's request registers and reaches
// its output register. One pin level per cycle from the sequencer while the output is not stalled;
// start and stop are three levels, a byte write 27, no gap between requests while levels are taken.
// Input is taken while the queue has room, even with a level waiting at the output.
// Reset (synchronous, active high) empties the queue and drives both lines released high.
// Holds the front end, request queue and pin sequencer; depends on i2cw_pkg.
`default_nettype none
module i2c_write_master_pins #(
  parameter int unsigned QUEUE_DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     cmd,
  input  wire logic [i2cw_pkg::BYTE_BITS-1:0] data_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                scl,
  output logic                                sda,
  output logic                                hold,
  output logic                                last
);

  logic               q_full;
  logic               push;
  logic               pop;
  i2cw_pkg::q_entry_t entry;
  i2cw_pkg::q_head_t  head;

  // Accept and classify requests
  i2cw_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .data_byte (data_byte),
    .q_full    (q_full),
    .push      (push),
    .entry     (entry)
  );

  // Decoupling queue
  i2cw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  // Pin level sequencer
  i2cw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl       (scl),
    .sda       (sda),
    .hold      (hold),
    .last      (last)
  );

endmodule
`default_nettype wire

[hdl/i2cw_checker.sv]
// Port-level checks for the I2C pin sequencer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module i2cw_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic scl,
  input wire logic sda,
  input wire logic hold,
  input wire logic last
);

  // A stalled level holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({scl, sda, hold, last}))
    else $error("output level changed while stalled");

  // Reset leaves nothing pending and input open
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output or input handshake wrong after reset");

  // Every request ends with SDA high whenever SCL is high
  a_last_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && scl |-> sda)
    else $error("request ended with SCL high and SDA low");

  // A level with no hold after it never leaves SCL high with SDA low
  a_nohold_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hold && scl |-> sda)
    else $error("unheld level with SCL high and SDA low");

endmodule

bind i2c_write_master_pins i2cw_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .scl       (scl),
  .sda       (sda),
  .hold      (hold),
  .last      (last)
);
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the write-only I2C pin sequencer.
// Drives start/write/stop requests and the unused code, predicts the pin levels and checks every one.
// Depends on i2cw_pkg and i2c_write_master_pins.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned LONG_HOLD      = 400;

  typedef struct {
    i2cw_pkg::cmd_e_t op;
    logic [7:0]       data;
    bit               drain;  // wait for all pin levels before offering
    bit               calm;   // no idling while this request is in flight
  } bus_req_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic hold;
    logic last;
  } pin_level_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd = i2cw_pkg::CMD_START;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl, sda, hold, last;

  bus_req_t   req_q[$];
  pin_level_t pin_levels_q[$];

  // predicted line state
  logic line_scl, line_sda;

  int unsigned errors = 0;
  int unsigned reqs_taken = 0;
  int unsigned unused_taken = 0;
  int unsigned levels_checked = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned long_cnt = 0;
  int unsigned quiet_cycles = 0;
  bit          stall_done = 1'b0;
  bit          idle_en = 1'b1;
  bus_req_t    nxt;
  pin_level_t  got, want;

  i2c_write_master_pins dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl       (scl),
    .sda       (sda),
    .hold      (hold),
    .last      (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the pin levels one bus request drives, updating the line state
  function automatic void predict_levels(input i2cw_pkg::cmd_e_t op, input logic [7:0] b);
    pin_level_t seq[$];
    logic [7:0] sh;
    sh = b;
    case (op)
      i2cw_pkg::CMD_START: begin
        seq.push_back('{1'b1, 1'b1, 1'b1, 1'b0});
        seq.push_back('{1'b1, 1'b0, 1'b1, 1'b0});
        seq.push_back('{1'b0, 1'b0, 1'b0, 1'b0});
        line_scl = 1'b0;
        line_sda = 1'b0;
      end
      i2cw_pkg::CMD_WRITE: begin
        for (int i = 0; i < i2cw_pkg::BYTE_BITS; i++) begin
          line_sda = sh[7];
          seq.push_back('{line_scl, line_sda, 1'b1, 1'b0});
          seq.push_back('{1'b1, line_sda, 1'b1, 1'b0});
          seq.push_back('{1'b0, line_sda, 1'b0, 1'b0});
          line_scl = 1'b0;
          sh = sh << 1;
        end
        // acknowledge slot: SDA released, clocked, never sampled
        seq.push_back('{line_scl, 1'b1, 1'b0, 1'b0});
        seq.push_back('{1'b1, 1'b1, 1'b1, 1'b0});
        seq.push_back('{1'b0, 1'b1, 1'b0, 1'b0});
        line_scl = 1'b0;
        line_sda = 1'b1;
      end
      i2cw_pkg::CMD_STOP: begin
        seq.push_back('{1'b0, 1'b0, 1'b1, 1'b0});
        seq.push_back('{1'b1, 1'b0, 1'b1, 1'b0});
        seq.push_back('{1'b1, 1'b1, 1'b1, 1'b0});
        line_scl = 1'b1;
        line_sda = 1'b1;
      end
      default: ;  // unused code: nothing driven, lines untouched
    endcase
    if (seq.size() > 0) seq[seq.size()-1].last = 1'b1;
    foreach (seq[k]) pin_levels_q.push_back(seq[k]);
  endfunction

  task automatic add_req(input i2cw_pkg::cmd_e_t op, input logic [7:0] b, input bit calm);
    req_q.push_back('{op, b, 1'b0, calm});
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
      // both lines released high out of reset
      line_scl = 1'b1;
      line_sda = 1'b1;
    end else begin
      if (in_valid && in_ready) begin
        predict_levels(i2cw_pkg::cmd_e_t'(cmd), data_byte);
        reqs_taken++;
        if (cmd == i2cw_pkg::CMD_NONE) unused_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0 && !(req_q[0].drain && pin_levels_q.size() != 0)) begin
          nxt = req_q.pop_front();
          in_valid  <= 1'b1;
          cmd       <= nxt.op;
          data_byte <= nxt.data;
          idle_en = !nxt.calm;
          if (!nxt.calm && $urandom_range(0, 3) == 0) tx_gap = $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Pin level monitor and back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{scl, sda, hold, last};
        if (pin_levels_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected pin level scl=%b sda=%b hold=%b last=%b",
                     $realtime, scl, sda, hold, last);
        end else begin
          want = pin_levels_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: pin level %0d: expected scl=%b sda=%b hold=%b last=%b,",
                        " got scl=%b sda=%b hold=%b last=%b"},
                       $realtime, levels_checked, want.scl, want.sda, want.hold,
                       want.last, scl, sda, hold, last);
          end
        end
        levels_checked++;
      end
      // one long hold-off so the request queue fills and in_ready drops
      if (!stall_done && levels_checked >= 300) begin
        stall_done = 1'b1;
        long_cnt = LONG_HOLD;
      end
      if (long_cnt > 0) long_cnt--;
      else if (rx_gap > 0) rx_gap--;
      else if (idle_en && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 14);
      out_ready <= (long_cnt == 0 && rx_gap == 0);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d pin levels still pending",
                 $realtime, pin_levels_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned counted;
    int unsigned nwr;
    bit          calm;
    bit          drain_set;

    // directed: write straight out of reset, byte extremes, ignored data,
    // unused code, and commands in odd orders
    add_req(i2cw_pkg::CMD_WRITE, 8'h3C, 1'b0);
    add_req(i2cw_pkg::CMD_NONE,  8'hFF, 1'b0);
    add_req(i2cw_pkg::CMD_START, 8'hFF, 1'b0);
    add_req(i2cw_pkg::CMD_WRITE, 8'h00, 1'b0);
    add_req(i2cw_pkg::CMD_WRITE, 8'hFF, 1'b0);
    add_req(i2cw_pkg::CMD_WRITE, 8'h80, 1'b0);
    add_req(i2cw_pkg::CMD_WRITE, 8'h01, 1'b0);
    add_req(i2cw_pkg::CMD_WRITE, 8'hA5, 1'b0);
    add_req(i2cw_pkg::CMD_STOP,  8'hAA, 1'b0);
    add_req(i2cw_pkg::CMD_WRITE, 8'h5A, 1'b0);
    add_req(i2cw_pkg::CMD_STOP,  8'h00, 1'b0);
    add_req(i2cw_pkg::CMD_STOP,  8'h55, 1'b0);
    add_req(i2cw_pkg::CMD_START, 8'h00, 1'b0);
    add_req(i2cw_pkg::CMD_NONE,  8'h00, 1'b0);
    add_req(i2cw_pkg::CMD_START, 8'h7F, 1'b0);
    add_req(i2cw_pkg::CMD_WRITE, 8'hFE, 1'b0);
    add_req(i2cw_pkg::CMD_START, 8'h01, 1'b0);
    add_req(i2cw_pkg::CMD_WRITE, 8'h7F, 1'b0);
    add_req(i2cw_pkg::CMD_STOP,  8'hFF, 1'b0);
    add_req(i2cw_pkg::CMD_START, 8'hC3, 1'b0);
    add_req(i2cw_pkg::CMD_STOP,  8'h3C, 1'b0);
    // hold the last directed request until all earlier pin levels have drained
    req_q[req_q.size()-1].drain = 1'b1;

    // random: mostly well-formed transactions, some noise and broken framing
    counted = 0;
    drain_set = 1'b0;
    while (counted < 300) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        add_req(i2cw_pkg::cmd_e_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), calm);
        if (req_q[req_q.size()-1].op != i2cw_pkg::CMD_NONE) counted++;
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          add_req(i2cw_pkg::CMD_START, 8'($urandom_range(0, 255)), calm);
          counted++;
        end
        nwr = $urandom_range(1, 4);
        repeat (nwr) begin
          add_req(i2cw_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), calm);
          counted++;
        end
        if ($urandom_range(0, 9) != 0) begin
          add_req(i2cw_pkg::CMD_STOP, 8'($urandom_range(0, 255)), calm);
          counted++;
        end
      end
      if (!drain_set && counted >= 150) begin
        drain_set = 1'b1;
        req_q[req_q.size()-1].drain = 1'b1;
      end
    end
    // tail of the run without idling
    for (int i = req_q.size() - 40; i < req_q.size(); i++) req_q[i].calm = 1'b1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (req_q.size() > 0 || in_valid) @(posedge clk);
    while (pin_levels_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d with the unused code) and %0d pin levels,",
             reqs_taken, unused_taken, levels_checked);
    $display("with random idling on both sides, one long output hold-off and sender drains.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hdl/i2cw_pkg.sv
hdl/i2cw_front.sv
hdl/i2cw_queue.sv
hdl/i2cw_seq.sv
hdl/i2c_write_master_pins.sv
hdl/i2cw_checker.sv
bench/tb.sv
